// File: src/uqd_pkg.sv
// ----------------------------------------------------------------------------
// uqd_pkg
// Shared widths, codes, state and control types of the micro-op queue.
// ----------------------------------------------------------------------------
package uqd_pkg;

   // default sizing
   localparam int QUEUE_DEPTH_DEF  = 32;
   localparam int MAX_DISPATCH_DEF = 8;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int CODE_W   = 32;
   localparam int SEQ_W    = 32;
   localparam int SLOTS_W  = 6;
   localparam int REASON_W = 4;
   localparam int KIND_W   = 2;
   localparam int OCC_W    = 6;
   localparam int CAP_W    = 6;
   localparam int DW_W     = 4;
   localparam int LIM_W    = 5;
   localparam int ENTRY_W  = CODE_W + SEQ_W + 1;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPATCH_WIDTH = 1'd1;
   localparam logic [CAP_W-1:0]     CAP_RESET = 6'd16;
   localparam logic [DW_W-1:0]      DW_RESET  = 4'd4;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SQUASH   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_STATUS   = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SQUASH   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } uqd_state_type;

   // controller to datapath
   typedef struct packed {
      logic ready;
      logic accept;
      logic exec;
      logic pop;
      logic emit;
   } uqd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_dispatch;
      logic out_free;
      logic scan_go;
      logic emit_last;
   } uqd_status_type;

endpackage

// File: src/uqd_req_if.sv
// ----------------------------------------------------------------------------
// uqd_req_if
// Request channel: enqueue, dispatch, squash and status items.
// ----------------------------------------------------------------------------
interface uqd_req_if
   import uqd_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CODE_W-1:0]   uop_code;
   logic                serializing;
   logic [SLOTS_W-1:0]  free_dispatch_slots;
   logic                core_synced;
   logic [REASON_W-1:0] squash_reason;

   modport source (
      output valid, opcode, uop_code, serializing, free_dispatch_slots,
             core_synced, squash_reason,
      input  ready
   );

   modport sink (
      input  valid, opcode, uop_code, serializing, free_dispatch_slots,
             core_synced, squash_reason,
      output ready
   );
endinterface

// File: src/uqd_rsp_if.sv
// ----------------------------------------------------------------------------
// uqd_rsp_if
// Response channel: dispatched micro-ops, squash notices and status.
// ----------------------------------------------------------------------------
interface uqd_rsp_if
   import uqd_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CODE_W-1:0]   out_code;
   logic [SEQ_W-1:0]    out_seq;
   logic [REASON_W-1:0] out_reason;
   logic [OCC_W-1:0]    occupancy;
   logic [OCC_W-1:0]    free_slots;
   logic                stalled;
   logic                sync_wait;
   logic                overflow;
   logic                last;

   modport source (
      output valid, kind, out_code, out_seq, out_reason, occupancy, free_slots,
             stalled, sync_wait, overflow, last,
      input  ready
   );

   modport sink (
      input  valid, kind, out_code, out_seq, out_reason, occupancy, free_slots,
             stalled, sync_wait, overflow, last,
      output ready
   );
endinterface

// File: src/uqd_ram.sv
// ----------------------------------------------------------------------------
// uqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/uqd_ctrl.sv
// ----------------------------------------------------------------------------
// uqd_ctrl
// Sequencer: accept, single-result ops, dispatch scan and result emission.
// ----------------------------------------------------------------------------
module uqd_ctrl
   import uqd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  uqd_status_type status,
   output uqd_cmd_type    cmd
);
   uqd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.in_dispatch ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!status.scan_go) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EXEC: cmd.exec = status.out_free;
         ST_SCAN: cmd.pop  = status.scan_go;
         ST_EMIT: cmd.emit = status.out_free;
      endcase
   end
endmodule

// File: src/uqd_dpath.sv
// ----------------------------------------------------------------------------
// uqd_dpath
// Queue storage, pointers, pop buffer, config registers and response register.
// ----------------------------------------------------------------------------
module uqd_dpath
   import uqd_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int MAX_DISPATCH = MAX_DISPATCH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  uqd_cmd_type           cmd,
   output uqd_status_type        status,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [CODE_W-1:0]     req_uop_code,
   input  logic                  req_serializing,
   input  logic [SLOTS_W-1:0]    req_free_dispatch_slots,
   input  logic                  req_core_synced,
   input  logic [REASON_W-1:0]   req_squash_reason,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   uqd_rsp_if.source             rsp_if
);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DONE_W = $clog2(MAX_DISPATCH + 1);
   localparam int IDX_W  = (MAX_DISPATCH > 1) ? $clog2(MAX_DISPATCH) : 1;
   localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_DISPATCH);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // latched item
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic                ser_ff, ser_in;
   logic [SLOTS_W-1:0]  slots_ff, slots_in;
   logic                synced_ff, synced_in;
   logic [REASON_W-1:0] reason_ff, reason_in;

   // queue state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [DONE_W-1:0] done_ff, done_in;
   logic [DONE_W-1:0] idx_ff, idx_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [DW_W-1:0]   dw_ff, dw_in;

   // popped micro-ops waiting for emission
   logic [CODE_W+SEQ_W-1:0] pop_buf_ff [MAX_DISPATCH];

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [CODE_W-1:0]   out_code_ff, out_code_in;
   logic [SEQ_W-1:0]    out_seq_ff, out_seq_in;
   logic [REASON_W-1:0] out_reason_ff, out_reason_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [OCC_W-1:0]    free_ff, free_in;
   logic                stalled_ff, stalled_in;
   logic                sync_wait_ff, sync_wait_in;
   logic                overflow_ff, overflow_in;
   logic                last_ff, last_in;

   // ram
   logic               ram_we;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               ram_ser;
   logic [SEQ_W-1:0]   ram_seq;
   logic [CODE_W-1:0]  ram_code;
   logic [SEQ_W-1:0]   seq_inc;

   logic             full;
   logic             out_free;
   logic             load;
   logic [LIM_W-1:0] limit;
   logic [CMP_W-1:0] cap_x, cnt_x;
   logic [CODE_W+SEQ_W-1:0] buf_rd;

   assign ram_ser  = ram_rdata[ENTRY_W-1];
   assign ram_seq  = ram_rdata[CODE_W +: SEQ_W];
   assign ram_code = ram_rdata[CODE_W-1:0];
   assign seq_inc  = seq_ff + 1'b1;
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign load     = cmd.exec || cmd.emit;
   assign limit    = ({1'b0, dw_ff} > MAX_LIM) ? MAX_LIM : {1'b0, dw_ff};
   assign buf_rd   = pop_buf_ff[idx_ff[IDX_W-1:0]];

   // read port follows the next head so data matches head_ff
   uqd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata ({ser_ff, seq_inc, code_ff}),
      .raddr (head_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      status.in_dispatch = (req_opcode == OP_DISPATCH);
      status.out_free    = out_free;
      status.scan_go     = (SLOTS_W'(done_ff) < slots_ff)
                        && (LIM_W'(done_ff) < limit)
                        && (count_ff != '0)
                        && !pend_ff
                        && (!ram_ser || (synced_ff && (done_ff == '0)));
      status.emit_last   = (done_ff == '0) || (DONE_W'(idx_ff + 1'b1) == done_ff);
   end

   always_comb begin
      op_in     = op_ff;
      code_in   = code_ff;
      ser_in    = ser_ff;
      slots_in  = slots_ff;
      synced_in = synced_ff;
      reason_in = reason_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      seq_in    = seq_ff;
      done_in   = done_ff;
      idx_in    = idx_ff;
      cap_in    = cap_ff;
      dw_in     = dw_ff;
      ram_we    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_QUEUE_CAPACITY: cap_in = csr_wdata[CAP_W-1:0];
            CSR_DISPATCH_WIDTH: dw_in  = csr_wdata[DW_W-1:0];
         endcase
      end

      if (cmd.accept) begin
         op_in     = req_opcode;
         code_in   = req_uop_code;
         ser_in    = req_serializing;
         slots_in  = req_free_dispatch_slots;
         synced_in = req_core_synced;
         reason_in = req_squash_reason;
         done_in   = '0;
         idx_in    = '0;
         // a synced core releases the serialization wait
         if (req_opcode == OP_DISPATCH && req_core_synced) begin
            pend_in = 1'b0;
         end
      end

      if (cmd.exec) begin
         unique case (op_ff)
            OP_ENQUEUE: begin
               if (!full) begin
                  seq_in   = seq_inc;
                  tail_in  = ptr_next(tail_ff);
                  count_in = count_ff + 1'b1;
                  ram_we   = 1'b1;
               end
            end
            OP_SQUASH: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            OP_DISPATCH, OP_STATUS: ;
         endcase
      end

      if (cmd.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - 1'b1;
         done_in  = done_ff + 1'b1;
         if (ram_ser) begin
            pend_in = 1'b1;
         end
      end

      if (cmd.emit && done_ff != '0) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // response payload; status fields reflect the state after the item
   always_comb begin
      kind_in       = KIND_STATUS;
      out_code_in   = '0;
      out_seq_in    = '0;
      out_reason_in = '0;
      overflow_in   = 1'b0;
      last_in       = 1'b1;
      if (cmd.exec) begin
         if (op_ff == OP_SQUASH) begin
            kind_in       = KIND_SQUASH;
            out_reason_in = reason_ff;
         end
         overflow_in = (op_ff == OP_ENQUEUE) && full;
      end else if (done_ff != '0) begin
         kind_in     = KIND_DISPATCH;
         out_code_in = buf_rd[CODE_W-1:0];
         out_seq_in  = buf_rd[CODE_W +: SEQ_W];
         last_in     = (DONE_W'(idx_ff + 1'b1) == done_ff);
      end
      cap_x        = CMP_W'(cap_ff);
      cnt_x        = CMP_W'(count_in);
      occ_in       = cnt_x[OCC_W-1:0];
      free_in      = (cap_x > cnt_x) ? OCC_W'(cap_x - cnt_x) : '0;
      stalled_in   = (count_in == '0) || (slots_ff == '0) || (pend_in && !synced_ff);
      sync_wait_in = pend_in;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         seq_ff       <= '0;
         done_ff      <= '0;
         idx_ff       <= '0;
         cap_ff       <= CAP_RESET;
         dw_ff        <= DW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         seq_ff       <= seq_in;
         done_ff      <= done_in;
         idx_ff       <= idx_in;
         cap_ff       <= cap_in;
         dw_ff        <= dw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      code_ff   <= code_in;
      ser_ff    <= ser_in;
      slots_ff  <= slots_in;
      synced_ff <= synced_in;
      reason_ff <= reason_in;
      if (cmd.pop) begin
         pop_buf_ff[done_ff[IDX_W-1:0]] <= {ram_seq, ram_code};
      end
      if (load) begin
         kind_ff       <= kind_in;
         out_code_ff   <= out_code_in;
         out_seq_ff    <= out_seq_in;
         out_reason_ff <= out_reason_in;
         occ_ff        <= occ_in;
         free_ff       <= free_in;
         stalled_ff    <= stalled_in;
         sync_wait_ff  <= sync_wait_in;
         overflow_ff   <= overflow_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = kind_ff;
   assign rsp_if.out_code   = out_code_ff;
   assign rsp_if.out_seq    = out_seq_ff;
   assign rsp_if.out_reason = out_reason_ff;
   assign rsp_if.occupancy  = occ_ff;
   assign rsp_if.free_slots = free_ff;
   assign rsp_if.stalled    = stalled_ff;
   assign rsp_if.sync_wait  = sync_wait_ff;
   assign rsp_if.overflow   = overflow_ff;
   assign rsp_if.last       = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (count_ff != '0) && !pend_ff)
      else $error("pop from empty or blocked queue");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("response overwritten before taken");

   a_serial_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && ram_ser) |=> pend_ff && !status.scan_go)
      else $error("serializing pop did not block dispatch");

   a_squash_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_SQUASH) |=> (count_ff == '0) && (head_ff == tail_ff))
      else $error("squash left entries");
endmodule

// File: src/uop_queue_dispatch_with_serializing.sv
// ----------------------------------------------------------------------------
// uop_queue_dispatch_with_serializing
// Micro-op queue between decode and dispatch with serializing micro-ops.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           carries
//  req_if    in         valid/ready         opcode, uop_code, serializing,
//                                           free_dispatch_slots, core_synced,
//                                           squash_reason
//  rsp_if    out        valid/ready         kind, out_code, out_seq, out_reason,
//                                           occupancy, free_slots, stalled,
//                                           sync_wait, overflow, last
//  csr_*     in         csr_we write only   queue_capacity (0), dispatch_width (1)
//
//  enqueue, squash and status: accept, then result load
//  dispatch popping k micro-ops: accept, then a scan with one queue ram
//    read per pop, then, while rsp_if is ready, one result per cycle from the pop buffer
//  reset is synchronous; the entry ram is not cleared and needs no sweep
//  an item is taken while the previous result still waits in the output register;
//    a result that cannot leave holds the sequencer until rsp_if.ready
// ----------------------------------------------------------------------------
module uop_queue_dispatch_with_serializing
   import uqd_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int MAX_DISPATCH = MAX_DISPATCH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   uqd_req_if.sink               req_if,
   uqd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   uqd_cmd_type    cmd;
   uqd_status_type status;

   // request ready comes straight from the sequencer
   assign req_if.ready = cmd.ready;

   // sequencer: idle, single-result op, dispatch scan, dispatch emission
   uqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, pointers, counters and the response register
   uqd_dpath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_DISPATCH (MAX_DISPATCH)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_opcode              (req_if.opcode),
      .req_uop_code            (req_if.uop_code),
      .req_serializing         (req_if.serializing),
      .req_free_dispatch_slots (req_if.free_dispatch_slots),
      .req_core_synced         (req_if.core_synced),
      .req_squash_reason       (req_if.squash_reason),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .rsp_if                  (rsp_if)
   );
endmodule

// File: sim/uqd_dispatch_checker.sv
// ----------------------------------------------------------------------------
// uqd_dispatch_checker
// Watches the request, response and csr traffic of the micro-op queue,
// keeps its own copy of the queue and predicts every response item.
// ----------------------------------------------------------------------------
module uqd_dispatch_checker
   import uqd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   uqd_req_if                    req_mon,
   uqd_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    fail_count
);

   localparam int QDEPTH     = QUEUE_DEPTH_DEF;
   localparam int MAXD       = MAX_DISPATCH_DEF;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CODE_W-1:0]   out_code;
      logic [SEQ_W-1:0]    out_seq;
      logic [REASON_W-1:0] out_reason;
      logic [OCC_W-1:0]    occupancy;
      logic [OCC_W-1:0]    free_slots;
      logic                stalled;
      logic                sync_wait;
      logic                overflow;
      logic                last;
   } uop_result_type;

   // shadow queue and configuration
   logic [CODE_W-1:0] slot_code   [QDEPTH];
   logic [SEQ_W-1:0]  slot_seq    [QDEPTH];
   logic              slot_serial [QDEPTH];
   int                head_idx;
   int                tail_idx;
   int                fill_count;
   logic              serial_wait;
   logic [SEQ_W-1:0]  seq_count;
   logic [CAP_W-1:0]  capacity_reg;
   logic [DW_W-1:0]   width_reg;

   uop_result_type pending_results_q[$];
   uop_result_type want_result;
   int             mismatch_count;
   int             result_count;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s got %0h want %0h",
                                   result_count, name, got, want));
   endtask

   // works out every response item caused by one request item
   task automatic predict_queue_results(
      input logic [OPCODE_W-1:0] op,
      input logic [CODE_W-1:0]   code,
      input logic                ser,
      input logic [SLOTS_W-1:0]  slots,
      input logic                synced,
      input logic [REASON_W-1:0] reason
   );
      uop_result_type batch[$];
      uop_result_type r;
      int             pop_limit;
      int             avail;
      int             popped;
      int             free_cnt;
      logic           stall;
      r = '0;
      case (op)
         OP_ENQUEUE: begin
            if (fill_count >= QDEPTH) begin
               r.overflow = 1'b1;
            end else begin
               seq_count             = seq_count + 1'b1;
               slot_code[tail_idx]   = code;
               slot_seq[tail_idx]    = seq_count;
               slot_serial[tail_idx] = ser;
               tail_idx              = (tail_idx + 1) % QDEPTH;
               fill_count++;
            end
            r.kind = KIND_STATUS;
            batch.insert(batch.size(), r);
         end
         OP_DISPATCH: begin
            pop_limit = (int'(width_reg) > MAXD) ? MAXD : int'(width_reg);
            avail     = int'(slots);
            popped    = 0;
            if (synced)
               serial_wait = 1'b0;
            while (avail > 0 && popped < pop_limit && fill_count > 0 && !serial_wait) begin
               // serializing op leaves only as first pop on a synced core
               if (slot_serial[head_idx]) begin
                  if (!(synced && popped == 0))
                     break;
                  serial_wait = 1'b1;
               end
               r          = '0;
               r.kind     = KIND_DISPATCH;
               r.out_code = slot_code[head_idx];
               r.out_seq  = slot_seq[head_idx];
               batch.insert(batch.size(), r);
               head_idx = (head_idx + 1) % QDEPTH;
               fill_count--;
               popped++;
               avail--;
            end
            if (batch.size() == 0) begin
               r      = '0;
               r.kind = KIND_STATUS;
               batch.insert(batch.size(), r);
            end
         end
         OP_SQUASH: begin
            head_idx     = 0;
            tail_idx     = 0;
            fill_count   = 0;
            r.kind       = KIND_SQUASH;
            r.out_reason = reason;
            batch.insert(batch.size(), r);
         end
         default: begin
            r.kind = KIND_STATUS;
            batch.insert(batch.size(), r);
         end
      endcase
      free_cnt = (int'(capacity_reg) > fill_count) ? int'(capacity_reg) - fill_count : 0;
      stall    = (fill_count == 0) || (slots == '0) || (serial_wait && !synced);
      foreach (batch[i]) begin
         batch[i].occupancy  = OCC_W'(fill_count);
         batch[i].free_slots = OCC_W'(free_cnt);
         batch[i].stalled    = stall;
         batch[i].sync_wait  = serial_wait;
         batch[i].last       = (i == batch.size() - 1);
         pending_results_q.insert(pending_results_q.size(), batch[i]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_idx     = 0;
         tail_idx     = 0;
         fill_count   = 0;
         serial_wait  = 1'b0;
         seq_count    = '0;
         capacity_reg = CAP_RESET;
         width_reg    = DW_RESET;
         pending_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_QUEUE_CAPACITY: capacity_reg = csr_wdata[CAP_W-1:0];
               CSR_DISPATCH_WIDTH: width_reg    = csr_wdata[DW_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_queue_results(req_mon.opcode, req_mon.uop_code, req_mon.serializing,
                                  req_mon.free_dispatch_slots, req_mon.core_synced,
                                  req_mon.squash_reason);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                         result_count));
            end else begin
               want_result = pending_results_q[0];
               pending_results_q.delete(0);
               check_field("kind",       32'(rsp_mon.kind),       32'(want_result.kind));
               check_field("out_code",   rsp_mon.out_code,        want_result.out_code);
               check_field("out_seq",    rsp_mon.out_seq,         want_result.out_seq);
               check_field("out_reason", 32'(rsp_mon.out_reason),
                           32'(want_result.out_reason));
               check_field("occupancy",  32'(rsp_mon.occupancy),
                           32'(want_result.occupancy));
               check_field("free_slots", 32'(rsp_mon.free_slots),
                           32'(want_result.free_slots));
               check_field("stalled",    32'(rsp_mon.stalled),    32'(want_result.stalled));
               check_field("sync_wait",  32'(rsp_mon.sync_wait),  32'(want_result.sync_wait));
               check_field("overflow",   32'(rsp_mon.overflow),   32'(want_result.overflow));
               check_field("last",       32'(rsp_mon.last),       32'(want_result.last));
            end
            result_count++;
         end
      end
      outstanding <= pending_results_q.size();
   end

   initial begin
      mismatch_count = 0;
      result_count   = 0;
   end

endmodule

// File: sim/uop_queue_dispatch_with_serializing_test.sv
// ----------------------------------------------------------------------------
// uop_queue_dispatch_with_serializing_test
// Drives enqueue, dispatch, squash and status items into the micro-op queue
// under bursty input and a stalling output, changes the csr settings between
// phases and lets the checker compare every response item.
// ----------------------------------------------------------------------------
module uop_queue_dispatch_with_serializing_test
   import uqd_pkg::*;
   ;

   // run shape
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 75;
   localparam int PRESSURE_PHASE = 2;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int CYCLE_LIMIT    = 400000;

   // random traffic mixes
   localparam int MODE_MIXED = 0;
   localparam int MODE_FILL  = 1;
   localparam int MODE_DRAIN = 2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CODE_W-1:0]   uop_code;
      logic                serializing;
      logic [SLOTS_W-1:0]  slots;
      logic                synced;
      logic [REASON_W-1:0] reason;
   } uop_req_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    pending_results;
   int                    fail_count;
   int                    cycle_count;
   int                    burst_left;
   logic                  pressure_go;
   logic                  pressure_done;

   uqd_req_if req_if ();
   uqd_rsp_if rsp_if ();

   uop_queue_dispatch_with_serializing u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicts and compares beside the block
   uqd_dispatch_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (pending_results),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL uop_queue_dispatch_with_serializing");
      $finish;
   end

   function automatic uop_req_type make_req(input logic [OPCODE_W-1:0] op,
                                            input logic [CODE_W-1:0] code,
                                            input logic ser,
                                            input logic [SLOTS_W-1:0] slots,
                                            input logic synced,
                                            input logic [REASON_W-1:0] reason);
      uop_req_type it;
      it.opcode      = op;
      it.uop_code    = code;
      it.serializing = ser;
      it.slots       = slots;
      it.synced      = synced;
      it.reason      = reason;
      return it;
   endfunction

   // one random item; unused fields are random too so every bit toggles
   function automatic uop_req_type random_req(input int mode);
      uop_req_type it;
      int          pick;
      int          slot_sel;
      int          ser_pct;
      pick    = $urandom_range(0, 99);
      ser_pct = (mode == MODE_FILL) ? 10 : 25;
      case (mode)
         MODE_FILL:
            it.opcode = (pick < 88) ? OP_ENQUEUE : (pick < 94) ? OP_DISPATCH :
                        (pick < 99) ? OP_STATUS : OP_SQUASH;
         MODE_DRAIN:
            it.opcode = (pick < 25) ? OP_ENQUEUE : (pick < 85) ? OP_DISPATCH :
                        (pick < 97) ? OP_STATUS : OP_SQUASH;
         default:
            it.opcode = (pick < 45) ? OP_ENQUEUE : (pick < 80) ? OP_DISPATCH :
                        (pick < 95) ? OP_STATUS : OP_SQUASH;
      endcase
      // mostly small slot counts, with zero and the top value mixed in
      slot_sel = $urandom_range(0, 9);
      if (slot_sel == 0)
         it.slots = '0;
      else if (slot_sel == 1)
         it.slots = '1;
      else if (slot_sel < 8)
         it.slots = SLOTS_W'($urandom_range(1, 8));
      else
         it.slots = SLOTS_W'($urandom_range(0, 63));
      it.uop_code    = $urandom;
      it.serializing = ($urandom_range(0, 99) < ser_pct);
      it.synced      = 1'($urandom_range(0, 1));
      it.reason      = REASON_W'($urandom_range(0, 15));
      return it;
   endfunction

   // offer one item, with bursts and random gaps in front of it
   task automatic send_req(input uop_req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid               <= 1'b1;
      req_if.opcode              <= it.opcode;
      req_if.uop_code            <= it.uop_code;
      req_if.serializing         <= it.serializing;
      req_if.free_dispatch_slots <= it.slots;
      req_if.core_synced         <= it.synced;
      req_if.squash_reason       <= it.reason;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // drop valid and wait until every predicted item has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, one per cycle
   task automatic write_config(input logic [CAP_W-1:0] cap, input logic [DW_W-1:0] width);
      csr_we    <= 1'b1;
      csr_index <= CSR_QUEUE_CAPACITY;
      csr_wdata <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_index <= CSR_DISPATCH_WIDTH;
      csr_wdata <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // directed walk at reset settings: empty queue, field extremes,
   // serializing ops in every position, squash with both reason extremes
   task automatic run_directed();
      // empty queue, stalled on no slots
      send_req(make_req(OP_STATUS,   32'h0,        1'b0, 6'd0,  1'b0, 4'd0));
      // dispatch on an empty queue gives a status item
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h0000_0000, 1'b0, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1, 4'd15));
      send_req(make_req(OP_ENQUEUE,  32'hA5A5_A5A5, 1'b0, 6'd0,  1'b0, 4'd0));
      // pops one, then halts at the serializing op on an unsynced core
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b0, 4'd0));
      // serializing op leaves first, sets the sync wait
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd1,  1'b1, 4'd0));
      // blocked by the sync wait
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b0, 4'd0));
      send_req(make_req(OP_STATUS,   32'h0,        1'b0, 6'd5,  1'b0, 4'd0));
      // synced core clears the wait even with no slots
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd0,  1'b1, 4'd0));
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h1111_0001, 1'b0, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h2222_0002, 1'b0, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h3333_0003, 1'b0, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h4444_0004, 1'b1, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h5555_0005, 1'b0, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h6666_0006, 1'b0, 6'd0,  1'b0, 4'd0));
      // serializing op in the middle of a burst stops the burst
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd2,  1'b1, 4'd0));
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      send_req(make_req(OP_ENQUEUE,  32'h7777_0007, 1'b1, 6'd0,  1'b0, 4'd0));
      send_req(make_req(OP_DISPATCH, 32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      // squash keeps the sync wait, then squash of an empty queue
      send_req(make_req(OP_SQUASH,   32'h0,        1'b0, 6'd0,  1'b0, 4'd15));
      send_req(make_req(OP_SQUASH,   32'h0,        1'b0, 6'd63, 1'b1, 4'd0));
      send_req(make_req(OP_STATUS,   32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1, 4'd15));
   endtask

   // receiver: stretches of different stall styles, plus one long hold
   initial begin
      int style;
      int seg_len;
      int k;
      pressure_done = 1'b0;
      forever begin
         if (pressure_go && !pressure_done) begin
            // long hold while the sender keeps offering, so the block backs up
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end else begin
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 80);
            for (k = 0; k < seg_len; k++) begin
               case (style)
                  0:       rsp_if.ready <= 1'b1;
                  1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
                  2:       rsp_if.ready <= ($urandom_range(0, 9) < 3);
                  default: rsp_if.ready <= ((k % 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // stimulus and verdict
   initial begin
      int               phase;
      int               n;
      int               mode;
      logic [CAP_W-1:0] cap_val;
      logic [DW_W-1:0]  width_val;
      reset                      <= 1'b1;
      csr_we                     <= 1'b0;
      csr_index                  <= '0;
      csr_wdata                  <= '0;
      req_if.valid               <= 1'b0;
      req_if.opcode              <= OP_STATUS;
      req_if.uop_code            <= '0;
      req_if.serializing         <= 1'b0;
      req_if.free_dispatch_slots <= '0;
      req_if.core_synced         <= 1'b0;
      req_if.squash_reason       <= '0;
      burst_left  = 0;
      pressure_go = 1'b0;
      mode        = MODE_MIXED;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         // extremes first, including width zero and width above the limit
         case (phase)
            0: begin cap_val = 6'd32; width_val = 4'd8;  end
            1: begin cap_val = 6'd1;  width_val = 4'd1;  end
            2: begin cap_val = 6'd0;  width_val = 4'd15; end
            3: begin cap_val = 6'd63; width_val = 4'd0;  end
            default: begin
               cap_val   = CAP_W'($urandom_range(1, 32));
               width_val = DW_W'($urandom_range(1, 8));
            end
         endcase
         write_config(cap_val, width_val);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0)
               mode = $urandom_range(MODE_MIXED, MODE_DRAIN);
            // fill hard early in the pressure phase, across the long receiver hold, to reach overflow
            if (phase == PRESSURE_PHASE && n < 45)
               mode = MODE_FILL;
            if (phase == PRESSURE_PHASE && n == 5)
               pressure_go = 1'b1;
            send_req(random_req(mode));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS uop_queue_dispatch_with_serializing");
      else
         $display("FAIL uop_queue_dispatch_with_serializing");
      $finish;
   end

endmodule

// File: sim.f
src/uqd_pkg.sv
src/uqd_req_if.sv
src/uqd_rsp_if.sv
src/uqd_ram.sv
src/uqd_ctrl.sv
src/uqd_dpath.sv
src/uop_queue_dispatch_with_serializing.sv
sim/uqd_dispatch_checker.sv
sim/uop_queue_dispatch_with_serializing_test.sv
